### rtl/core/wst_pkg.sv
// Package for the weighted sum-tree sampler: payload types, codes and sizes.
`default_nettype none
package wst_pkg;
   localparam int LeavesDefault    = 1024;
   localparam int TreeDepthDefault = 10;
   localparam int SlotW  = 10;
   localparam int WeightW = 24;
   localparam int ValueW = 58;
   localparam int SumW   = 34;
   localparam int CountW = 11;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_PICK   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_UNUSED = 2'd2,
      ST_EMPTY = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [SlotW-1:0]   slot_id;
      logic [WeightW-1:0] weight;
      logic [ValueW-1:0]  pick_value;
      logic [WeightW-1:0] base_rate;
   } req_type_type;

   typedef struct packed {
      logic [SlotW-1:0]  slot_out;
      logic [1:0]        status;
      logic [SumW-1:0]   total_sum;
      logic [CountW-1:0] item_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request, start at root or leaf
      logic clr_step; // write one clear address
      logic rd;       // issue node read
      logic mul;      // register product
      logic wr;       // write node (except on a pick) and advance
      logic finish;   // update totals, build response
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic walk_done;
      logic reject;
   } dp_status_type;
endpackage
`default_nettype wire

### rtl/core/wst_datapath.sv
// Datapath: node memory, slot memory, walk registers and pick arithmetic.
`default_nettype none
module wst_datapath
   import wst_pkg::*;
#(
   parameter int LEAVES     = LeavesDefault,
   parameter int TREE_DEPTH = TreeDepthDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type_type  req_in,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      stat,
   output rsp_type            rsp_data
);
   localparam int NodeW = TREE_DEPTH + 1;
   localparam int LvlW  = $clog2(TREE_DEPTH + 1);
   localparam int IdxW  = TREE_DEPTH;

   // node memory: left sum, left fill, right fill (node 0 unused)
   logic [SumW+2*CountW-1:0] node_mem [LEAVES];
   // slot memory: used flag and weight
   logic [WeightW:0]         slot_mem [LEAVES];

   req_type_type      r_ff;
   logic [NodeW-1:0]  node_ff, node_in;
   logic [LvlW-1:0]   lvl_ff;
   logic [IdxW-1:0]   clr_ff;
   logic              clr_done_ff;
   logic [SumW+2*CountW-1:0] nrd_ff;
   logic [WeightW:0]  srd_ff;
   logic [ValueW-1:0] val_ff;
   logic [ValueW-1:0] prod_ff;
   logic [SumW-1:0]   total_ff;
   logic [CountW-1:0] count_ff;
   logic [IdxW-1:0]   leaf_slot_ff;
   rsp_type           rsp_ff;

   logic [SumW-1:0]   lsum;
   logic [CountW-1:0] lf, rf;
   logic [IdxW-1:0]   idx;
   logic              go_left, is_left;
   logic [SumW-1:0]   old_w, new_w;
   logic [SumW+2*CountW-1:0] nwr;
   logic [IdxW-1:0]   req_slot;
   logic              slot_range_ok;

   assign {lsum, lf, rf} = nrd_ff;
   assign idx     = node_ff[IdxW-1:0];
   assign old_w   = SumW'(srd_ff[WeightW-1:0]);
   assign new_w   = SumW'(r_ff.weight);
   assign req_slot = r_ff.slot_id[IdxW-1:0];
   assign slot_range_ok = (32'(r_ff.slot_id) < 32'(LEAVES));

   // direction and rewritten node for the current step
   always_comb begin
      go_left = 1'b0;
      is_left = 1'b0;
      nwr     = nrd_ff;
      node_in = node_ff;
      case (req_code_type'(r_ff.req_type))
         REQ_INSERT: begin
            go_left = (lf <= rf);
            if (go_left) begin
               nwr     = {lsum + new_w, lf + 1'b1, rf};
               node_in = {node_ff[NodeW-2:0], 1'b0};
            end else begin
               nwr     = {lsum, lf, rf + 1'b1};
               node_in = {node_ff[NodeW-2:0], 1'b1};
            end
         end
         REQ_REMOVE: begin
            is_left = ~node_ff[0];
            node_in = node_ff >> 1;
            if (is_left) nwr = {lsum - old_w, lf - 1'b1, rf};
            else nwr = {lsum, lf, rf - 1'b1};
         end
         REQ_UPDATE: begin
            is_left = ~node_ff[0];
            node_in = node_ff >> 1;
            if (is_left) nwr = {lsum - old_w + new_w, lf, rf};
         end
         default: begin
            go_left = (val_ff <= prod_ff);
            node_in = {node_ff[NodeW-2:0], ~go_left};
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         node_mem[clr_ff] <= '0;
         slot_mem[clr_ff] <= '0;
      end else if (cmd.wr && r_ff.req_type != REQ_PICK) begin
         node_mem[(r_ff.req_type == REQ_INSERT) ? idx
                  : node_in[IdxW-1:0]] <= nwr;
      end else if (cmd.finish && !stat.reject && r_ff.req_type != REQ_PICK) begin
         if (r_ff.req_type == REQ_INSERT) slot_mem[leaf_slot_ff] <= {1'b1, r_ff.weight};
         else if (r_ff.req_type == REQ_REMOVE) slot_mem[req_slot] <= '0;
         else slot_mem[req_slot] <= {1'b1, r_ff.weight};
      end
      if (cmd.rd) begin
         nrd_ff <= node_mem[(r_ff.req_type == REQ_INSERT || r_ff.req_type == REQ_PICK)
                            ? idx : node_ff[IdxW:1]];
      end
      if (cmd.load) srd_ff <= slot_mem[req_in.slot_id[IdxW-1:0]];
   end

   // clear sweep after reset, running total and item count
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         total_ff    <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
            if (&clr_ff) clr_done_ff <= 1'b1;
         end
         if (cmd.finish && !stat.reject) begin
            case (req_code_type'(r_ff.req_type))
               REQ_INSERT: begin
                  total_ff <= total_ff + new_w;
                  count_ff <= count_ff + 1'b1;
               end
               REQ_REMOVE: begin
                  total_ff <= (count_ff == CountW'(1)) ? '0 : total_ff - old_w;
                  count_ff <= count_ff - 1'b1;
               end
               REQ_UPDATE: total_ff <= total_ff - old_w + new_w;
               default: ;
            endcase
         end
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff   <= req_in;
         val_ff <= req_in.pick_value;
         lvl_ff <= '0;
         if (req_in.req_type == REQ_REMOVE || req_in.req_type == REQ_UPDATE)
            node_ff <= {1'b1, req_in.slot_id[IdxW-1:0]};
         else
            node_ff <= NodeW'(1);
      end
      if (cmd.mul) prod_ff <= ValueW'(lsum) * ValueW'(r_ff.base_rate);
      if (cmd.wr) begin
         node_ff <= node_in;
         lvl_ff  <= lvl_ff + 1'b1;
         if (r_ff.req_type == REQ_PICK && !go_left) val_ff <= val_ff - prod_ff;
         if (r_ff.req_type == REQ_INSERT || r_ff.req_type == REQ_PICK)
            leaf_slot_ff <= node_in[IdxW-1:0];
      end
   end

   // response
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.total_sum  <= total_ff;
         rsp_ff.item_count <= count_ff;
         rsp_ff.status     <= ST_OK;
         rsp_ff.slot_out   <= SlotW'(leaf_slot_ff);
         case (req_code_type'(r_ff.req_type))
            REQ_INSERT: if (stat.reject) begin
               rsp_ff.status <= ST_FULL; rsp_ff.slot_out <= '0;
            end else begin
               rsp_ff.total_sum  <= total_ff + new_w;
               rsp_ff.item_count <= count_ff + 1'b1;
            end
            REQ_REMOVE, REQ_UPDATE: begin
               rsp_ff.slot_out <= r_ff.slot_id;
               if (stat.reject) rsp_ff.status <= ST_UNUSED;
               else if (r_ff.req_type == REQ_REMOVE) begin
                  rsp_ff.total_sum  <= (count_ff == CountW'(1)) ? '0 : total_ff - old_w;
                  rsp_ff.item_count <= count_ff - 1'b1;
               end else rsp_ff.total_sum <= total_ff - old_w + new_w;
            end
            default: if (stat.reject) begin
               rsp_ff.status <= ST_EMPTY; rsp_ff.slot_out <= '0;
            end
         endcase
      end
   end

   // status to controller
   always_comb begin
      stat.clr_done  = clr_done_ff;
      stat.walk_done = (32'(lvl_ff) == 32'(TREE_DEPTH));
      case (req_code_type'(r_ff.req_type))
         REQ_INSERT: stat.reject = (32'(count_ff) >= 32'(LEAVES));
         REQ_PICK:   stat.reject = (count_ff == '0);
         default:    stat.reject = ~(slot_range_ok && srd_ff[WeightW]);
      endcase
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

### rtl/core/wst_ctrl.sv
// Controller: sequences the clear sweep and the per-level tree walk.
`default_nettype none
module wst_ctrl
   import wst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type stat,
   output dp_cmd_type         cmd
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_READ, S_MUL, S_WRITE, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = ~stat.clr_done;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = stat.reject ? S_DONE : S_READ;
         S_READ: begin
            if (stat.walk_done) state_in = S_DONE;
            else begin
               cmd.rd = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr = 1'b1;
            state_in = S_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

### rtl/core/weighted_sum_tree_sampler.sv
// Each tree level costs a node read, a product register and a node write;
// a rejected request skips the walk and goes straight to the response.
// The response register lets the next request enter while a response waits, but a
// new request is taken only after the previous one has reached the response register.
// Reset: a sweep over addresses 0 to 2**TREE_DEPTH-1 clears both memories; requests wait
// until it is done.
`default_nettype none
module weighted_sum_tree_sampler
   import wst_pkg::*;
#(
   parameter int LEAVES     = LeavesDefault,
   parameter int TREE_DEPTH = TreeDepthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data
);
   dp_cmd_type    cmd;
   dp_status_type stat;

   wst_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   wst_datapath #(.LEAVES(LEAVES), .TREE_DEPTH(TREE_DEPTH)) u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .stat, .rsp_data
   );
endmodule
`default_nettype wire
